[sv/dnsle_pkg.sv]
// package for the dns name label encoder
// holds the label size constants, the dot code and the controller/datapath structs
// no dependencies
package dnsle_pkg;

  localparam int unsigned MAX_LABEL_DEF = 62;
  localparam logic [7:0]  DOT_CHAR      = 8'h2E;
  localparam logic [7:0]  TERM_BYTE     = 8'h00;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_SEND_LEN  = 4'b0010,
    ST_SEND_DATA = 4'b0100,
    ST_SEND_TERM = 4'b1000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take_char;   // store an ordinary character
    logic start_run;   // latch the kind of run (dot or end of name)
    logic send_len;    // load the length byte into the output register
    logic send_data;   // load the next label byte into the output register
    logic send_term;   // load the zero terminator
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_is_end;   // presented item ends the name
    logic in_is_dot;   // presented item is a dot
    logic len_zero;    // open label is empty
    logic data_last;   // output register takes the final label byte now
    logic run_is_end;  // current run was started by an end of name
    logic out_free;    // output register can take a byte this cycle
  } sts_t;

endpackage

[sv/dnsle_ctrl.sv]
// controller state machine of the dns name label encoder
// sequences length, label bytes and terminator; uses dnsle_pkg
module dnsle_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dnsle_pkg::sts_t sts,
  output dnsle_pkg::cmd_t cmd
);
  import dnsle_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.take_char = accept && !sts.in_is_end && !sts.in_is_dot;
    cmd.start_run = accept && (sts.in_is_end || sts.in_is_dot);
    cmd.send_len  = (state_r == ST_SEND_LEN)  && sts.out_free;
    cmd.send_data = (state_r == ST_SEND_DATA) && sts.out_free;
    cmd.send_term = (state_r == ST_SEND_TERM) && sts.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.in_is_end) begin
          state_nxt = sts.len_zero ? ST_SEND_TERM : ST_SEND_LEN;
        end else if (accept && sts.in_is_dot) begin
          state_nxt = ST_SEND_LEN;
        end
      end
      ST_SEND_LEN: begin
        if (sts.out_free) begin
          if (!sts.len_zero) begin
            state_nxt = ST_SEND_DATA;
          end else begin
            state_nxt = sts.run_is_end ? ST_SEND_TERM : ST_IDLE;
          end
        end
      end
      ST_SEND_DATA: begin
        if (sts.out_free && sts.data_last) begin
          state_nxt = sts.run_is_end ? ST_SEND_TERM : ST_IDLE;
        end
      end
      ST_SEND_TERM: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/dnsle_dp.sv]
// datapath of the dns name label encoder
// label buffer memory, length and overflow registers, output register; uses dnsle_pkg
module dnsle_dp #(
  parameter int unsigned MAX_LABEL = dnsle_pkg::MAX_LABEL_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_ch,
  input  logic            in_end_name,
  input  dnsle_pkg::cmd_t cmd,
  output dnsle_pkg::sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            out_truncated
);
  import dnsle_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LABEL + 1);
  localparam int unsigned AW    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LABEL);
  localparam logic [LEN_W-1:0] ONE     = LEN_W'(1);

  logic [7:0]       mem [MAX_LABEL];
  logic [7:0]       rd_data_r;
  logic [LEN_W-1:0] len_r, ptr_r;
  logic             ovf_r, end_r;
  logic             out_valid_r, out_last_r, out_trunc_r;
  logic [7:0]       out_byte_r;
  logic             clear_label, len_full, any_load;

  assign len_full = (len_r == MAX_LEN);

  // status to the controller
  assign sts.in_is_end  = in_end_name;
  assign sts.in_is_dot  = (in_ch == DOT_CHAR);
  assign sts.len_zero   = (len_r == '0);
  assign sts.data_last  = (ptr_r == len_r);
  assign sts.run_is_end = end_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // label done: after the last byte of a dot run, or at the terminator
  assign clear_label = (cmd.send_len && sts.len_zero && !end_r) ||
                       (cmd.send_data && sts.data_last && !end_r) ||
                       cmd.send_term;
  assign any_load    = cmd.send_len || cmd.send_data || cmd.send_term;

  // label buffer write and prefetching read
  always_ff @(posedge clk) begin
    if (cmd.take_char && !len_full) begin
      mem[len_r[AW-1:0]] <= in_ch;
    end
    if (cmd.send_len && !sts.len_zero) begin
      rd_data_r <= mem[0];
    end else if (cmd.send_data && !sts.data_last) begin
      rd_data_r <= mem[ptr_r[AW-1:0]];
    end
  end

  // read pointer, one past the byte held in rd_data_r
  always_ff @(posedge clk) begin
    if (cmd.send_len) begin
      ptr_r <= ONE;
    end else if (cmd.send_data && !sts.data_last) begin
      ptr_r <= ptr_r + ONE;
    end
  end

  // length, overflow and run kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      end_r <= 1'b0;
    end else begin
      if (cmd.start_run) begin
        end_r <= in_end_name;
      end
      if (clear_label) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.take_char) begin
        if (len_full) begin
          ovf_r <= 1'b1;
        end else begin
          len_r <= len_r + ONE;
        end
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.send_len) begin
      out_byte_r  <= 8'(len_r);
      out_last_r  <= sts.len_zero && !end_r;
      out_trunc_r <= ovf_r;
    end else if (cmd.send_data) begin
      out_byte_r  <= rd_data_r;
      out_last_r  <= sts.data_last && !end_r;
      out_trunc_r <= ovf_r;
    end else if (cmd.send_term) begin
      out_byte_r  <= TERM_BYTE;
      out_last_r  <= 1'b1;
      out_trunc_r <= ovf_r;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (any_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_truncated   = out_trunc_r;

endmodule

[sv/dns_name_label_encoder_unit.sv]
// top level of the dns name label encoder
// joins dnsle_ctrl and dnsle_dp; uses dnsle_pkg
//
// Usage: a host name enters on the in_ channel one character per transfer
// (in_ch), with a final transfer carrying in_end_name = 1. Encoded wire bytes
// leave on the out_ channel: length byte, label bytes, and after the end of
// name a zero terminator. out_last_of_run marks the final byte caused by one
// input transfer; out_truncated flags a label that lost characters past
// MAX_LABEL.
// Throughput: an ordinary character is taken and produces nothing. A dot
// gives len + 1 output bytes at one per cycle while out_ready is high, an
// end of name len + 2 (or 1 for an empty label), paced by the single output
// register; in_ready stays low while a run is sent. The first byte of a run
// enters the output register after a dot or end transfer has moved the
// controller to ST_SEND_LEN, or to ST_SEND_TERM for an empty end label.
// Receiver stall: the output register holds its byte while out_ready is low
// and the sequencer waits. Reset clears the label length, overflow flag,
// controller state and out_valid; the label buffer needs no clearing.
module dns_name_label_encoder_unit #(
  parameter int unsigned MAX_LABEL = dnsle_pkg::MAX_LABEL_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_name,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_truncated
);
  import dnsle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dnsle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dnsle_dp #(
    .MAX_LABEL (MAX_LABEL)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .in_end_name     (in_end_name),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_truncated   (out_truncated)
  );

  // a dot or end of name blocks the input while its run is sent
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_end_name || in_ch == DOT_CHAR) |=> !in_ready)
    else $error("input taken while a run is starting");

  // at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take_char, cmd.start_run, cmd.send_len, cmd.send_data, cmd.send_term}))
    else $error("conflicting datapath commands");

  // bytes are loaded only into a free output register
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.send_len || cmd.send_data || cmd.send_term) |-> sts.out_free)
    else $error("output register overwritten");

endmodule
